### rtl/core/mecm_pkg.sv
// Shared types and constants for the mecanum drive mixer with slew limiting.
// Used by every module in rtl/core; depends on nothing else.
package mecm_pkg;

  localparam int WHEELS    = 4;
  localparam int WIDX_W    = 2;
  localparam int STICK_W   = 8;
  localparam int MIX_W     = 20;   // signed Q8 mix term
  localparam int MAG_W     = 19;   // magnitude of a mix term
  localparam int NUM_W     = 26;   // 127 times a magnitude
  localparam int QUO_W     = 7;    // quotient never exceeds 127
  localparam int QBIT_W    = 3;
  localparam int SPEED_W   = 8;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = QPTR_W + 1;
  localparam int RATE_W    = 9;
  localparam logic [RATE_W-1:0] RATE_ONE = 9'd256;

  typedef logic signed [MIX_W-1:0] mix_t;

  typedef struct packed {
    logic                    link;
    mix_t [WHEELS-1:0]       mix;
  } mix_item_t;

  typedef struct packed {
    logic [6:0]        deadband;
    logic [10:0]       yaw_gain;
    logic [15:0]       norm_floor;
    logic [RATE_W-1:0] step_rate;
  } cfg_t;

  typedef enum logic [1:0] {
    CFG_DEADBAND   = 2'd0,
    CFG_YAW_GAIN   = 2'd1,
    CFG_NORM_FLOOR = 2'd2,
    CFG_STEP_RATE  = 2'd3
  } cfg_idx_t;

endpackage

### rtl/core/mecanum_drive_mixer_with_slew_top.sv
// A live update passes the front register, the queue and the back end; an
// update with the link down goes from accept straight to the finishing step.
// The back end takes no new update until it has finished the last one: its
// shared restoring divider works through accept, a maximum search over all four
// wheels, per wheel a load, seven quotient bits and a slew step, and finishing.
// Synchronous active-low reset clears the queue, the wheel speeds and the
// registers to 15, 463, 2796 and 115.
module mecanum_drive_mixer_with_slew_top import mecm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // forward_raw [7:0], strafe_raw [15:8], yaw_raw [23:16]
  input  logic        in_tuser,   // link_ok
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // front_left, front_right, back_left, back_right drive
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t       cfg_r, cfg_nxt;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  mix_item_t  push_item, pop_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEADBAND:   cfg_nxt.deadband   = cfg_data[6:0];
        CFG_YAW_GAIN:   cfg_nxt.yaw_gain   = cfg_data[10:0];
        CFG_NORM_FLOOR: cfg_nxt.norm_floor = cfg_data;
        CFG_STEP_RATE:  cfg_nxt.step_rate  = (cfg_data[8:0] > RATE_ONE) ? RATE_ONE
                                                                        : cfg_data[8:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband   <= 7'd15;
      cfg_r.yaw_gain   <= 11'd463;
      cfg_r.norm_floor <= 16'd2796;
      cfg_r.step_rate  <= 9'd115;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mecm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  mecm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  mecm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### rtl/core/mecm_front.sv
// Front end: accepts drive updates, applies the deadband and clamp, and forms
// the four Q8 mix terms. Depends on mecm_pkg.
module mecm_front import mecm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [23:0]     in_tdata,   // forward_raw, strafe_raw, yaw_raw
  input  logic            in_tuser,   // link_ok
  input  cfg_t            cfg,
  output logic            push_valid,
  input  logic            push_ready,
  output mix_item_t       push_item
);

  logic                        s1_valid_r, s1_valid_nxt;
  logic signed [STICK_W-1:0]   f_r, s_r, y_r;
  logic                        link_r;
  logic signed [MIX_W-1:0]     fw, sw, ky;
  logic                        accept;

  function automatic logic signed [STICK_W-1:0] clean_stick(
    input logic signed [STICK_W-1:0] v,
    input logic [6:0]                db
  );
    logic [STICK_W-1:0] mag;
    mag = v[STICK_W-1] ? (~v + 8'd1) : v;
    if (mag < {1'b0, db}) begin
      return '0;
    end else if (v == -8'sd128) begin
      return -8'sd127;
    end else begin
      return v;
    end
  endfunction

  assign accept       = in_tvalid && in_tready;
  assign in_tready    = !s1_valid_r || push_ready;
  assign s1_valid_nxt = accept ? 1'b1 : (push_ready ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (accept) begin
      f_r    <= clean_stick(in_tdata[7:0],   cfg.deadband);
      s_r    <= clean_stick(in_tdata[15:8],  cfg.deadband);
      y_r    <= clean_stick(in_tdata[23:16], cfg.deadband);
      link_r <= in_tuser;
    end
  end

  assign fw = MIX_W'(signed'({f_r, 8'h00}));
  assign sw = MIX_W'(signed'({s_r, 8'h00}));
  assign ky = MIX_W'(signed'({1'b0, cfg.yaw_gain})) * MIX_W'(y_r);

  assign push_valid       = s1_valid_r;
  assign push_item.link   = link_r;
  assign push_item.mix[0] = fw - sw - ky;
  assign push_item.mix[1] = fw + sw + ky;
  assign push_item.mix[2] = fw + sw - ky;
  assign push_item.mix[3] = fw - sw + ky;

endmodule

### rtl/core/mecm_queue.sv
// Two-entry queue of mixed updates between the front end and the back end.
// Depends on mecm_pkg.
module mecm_queue import mecm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  mix_item_t  push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output mix_item_t  pop_item
);

  mix_item_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               push, pop;

  assign push_ready = count_r != QCNT_W'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### rtl/core/mecm_back.sv
// Back end: finds the normalising divisor, divides each wheel term serially,
// applies the slew step to the stored wheel speeds and holds the result; an
// update with the link down gives zeros. Depends on mecm_pkg.
module mecm_back import mecm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  mix_item_t   pop_item,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata
);

  typedef enum logic [2:0] {
    IDLE, MAXS, LOAD, DIV, SLEW, FINISH
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      link_r, link_nxt;
  mix_t [WHEELS-1:0]         mix_r, mix_nxt;
  logic [WIDX_W-1:0]         idx_r, idx_nxt;
  logic [MAG_W-1:0]          maxm_r, maxm_nxt, den_r, den_nxt;
  logic [NUM_W-1:0]          rem_r, rem_nxt;
  logic [QUO_W-1:0]          q_r, q_nxt;
  logic [QBIT_W-1:0]         bit_r, bit_nxt;
  logic                      neg_r, neg_nxt;
  logic signed [SPEED_W-1:0] speed_r [WHEELS];
  logic signed [SPEED_W-1:0] speed_nxt [WHEELS];
  logic                      out_valid_r, out_valid_nxt;
  logic [31:0]               out_data_r, out_data_nxt;

  mix_t                      cur_mix;
  logic [MAG_W-1:0]          cur_mag, new_max;
  logic [NUM_W-1:0]          trial;
  logic signed [8:0]         slew_tgt, slew_cur, slew_diff, slew_new;
  logic [7:0]                adiff, chg;
  logic [16:0]               prod;
  logic                      out_free;

  assign cur_mix   = mix_r[idx_r];
  assign cur_mag   = MAG_W'(cur_mix[MIX_W-1] ? -cur_mix : cur_mix);
  assign new_max   = (cur_mag > maxm_r) ? cur_mag : maxm_r;
  assign trial     = NUM_W'(den_r) << bit_r;
  assign out_free  = !out_valid_r || out_tready;
  assign pop_ready = state_r == IDLE;

  // Slew step: move by the rate fraction of the gap, at least one count.
  always_comb begin
    slew_tgt  = (den_r == '0) ? 9'sd0 :
                (neg_r ? -9'(signed'({2'b00, q_r})) : 9'(signed'({2'b00, q_r})));
    slew_cur  = 9'(speed_r[idx_r]);
    slew_diff = slew_tgt - slew_cur;
    adiff     = 8'(slew_diff[8] ? -slew_diff : slew_diff);
    prod      = 17'(adiff) * 17'(cfg.step_rate);
    chg       = 8'(prod >> 8);
    if (slew_diff != 9'sd0 && chg == 8'd0) begin
      chg = 8'd1;
    end
    slew_new  = slew_diff[8] ? slew_cur - 9'(signed'({1'b0, chg}))
                             : slew_cur + 9'(signed'({1'b0, chg}));
  end

  always_comb begin
    state_nxt     = state_r;
    link_nxt      = link_r;
    mix_nxt       = mix_r;
    idx_nxt       = idx_r;
    maxm_nxt      = maxm_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    bit_nxt       = bit_r;
    neg_nxt       = neg_r;
    speed_nxt     = speed_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      IDLE: begin
        if (pop_valid) begin
          link_nxt  = pop_item.link;
          mix_nxt   = pop_item.mix;
          idx_nxt   = '0;
          maxm_nxt  = '0;
          state_nxt = pop_item.link ? MAXS : FINISH;
        end
      end
      MAXS: begin
        maxm_nxt = new_max;
        if (idx_r == WIDX_W'(WHEELS - 1)) begin
          den_nxt   = (new_max > MAG_W'(cfg.norm_floor)) ? new_max : MAG_W'(cfg.norm_floor);
          idx_nxt   = '0;
          state_nxt = LOAD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      LOAD: begin
        rem_nxt   = (NUM_W'(cur_mag) << 7) - NUM_W'(cur_mag);
        neg_nxt   = cur_mix[MIX_W-1];
        q_nxt     = '0;
        bit_nxt   = QBIT_W'(QUO_W - 1);
        state_nxt = DIV;
      end
      DIV: begin
        if (rem_r >= trial) begin
          rem_nxt      = rem_r - trial;
          q_nxt[bit_r] = 1'b1;
        end
        if (bit_r == '0) begin
          state_nxt = SLEW;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      SLEW: begin
        speed_nxt[idx_r] = slew_new[SPEED_W-1:0];
        if (idx_r == WIDX_W'(WHEELS - 1)) begin
          state_nxt = FINISH;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = LOAD;
        end
      end
      FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = link_r ? {speed_r[3], speed_r[2], speed_r[1], speed_r[0]} : '0;
          state_nxt     = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
      speed_r     <= '{default: '0};
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      speed_r     <= speed_nxt;
    end
    link_r     <= link_nxt;
    mix_r      <= mix_nxt;
    idx_r      <= idx_nxt;
    maxm_r     <= maxm_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    bit_r      <= bit_nxt;
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A step toward the target never passes it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SLEW && slew_tgt >= slew_cur) |-> (slew_new >= slew_cur && slew_new <= slew_tgt))
    else $error("slew step overshoots upward");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SLEW && slew_tgt < slew_cur) |-> (slew_new < slew_cur && slew_new >= slew_tgt))
    else $error("slew step overshoots downward");

  assert property (@(posedge clk) disable iff (!rst_n)
    (speed_r[0] != -8'sd128 && speed_r[1] != -8'sd128 &&
     speed_r[2] != -8'sd128 && speed_r[3] != -8'sd128))
    else $error("wheel speed left the symmetric range");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == FINISH)
    else $error("result presented outside the finishing step");

endmodule
